>>> rtl/utpcc_pkg.sv
// Shared types and codes for the uTP connection control block.
package utpcc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SYN_SENT  = 3'd1,
        PH_CONNECTED = 3'd2,
        PH_FINISHED  = 3'd3,
        PH_CLOSED    = 3'd4
    } phase_t;

    localparam logic [2:0] KIND_PACKET  = 3'd0;
    localparam logic [2:0] KIND_TIMEOUT = 3'd1;
    localparam logic [2:0] KIND_RTT     = 3'd2;
    localparam logic [2:0] KIND_OPEN    = 3'd3;
    localparam logic [2:0] KIND_CLOSE   = 3'd4;
    localparam logic [2:0] KIND_RESET   = 3'd5;

    localparam logic [3:0] PK_DATA  = 4'd0;
    localparam logic [3:0] PK_FIN   = 4'd1;
    localparam logic [3:0] PK_STATE = 4'd2;
    localparam logic [3:0] PK_SYN   = 4'd4;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONNECT_TIMEOUT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TIMEOUT     = 1'b1;

    localparam logic [17:0] CONNECT_TIMEOUT_RST = 18'd3000;
    localparam logic [17:0] MAX_TIMEOUT_RST     = 18'd30000;
    localparam logic [17:0] RTO_BASE            = 18'd1000;
    localparam logic [19:0] RTO_FLOOR           = 20'd500;
    localparam logic [17:0] RTO_MAX             = 18'h3FFFF;
    localparam logic [17:0] RTO_HALF            = 18'h1FFFF;
    localparam logic [16:0] SRTT_RST            = 17'd100;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  pkt_type;
        logic [15:0] pkt_seq;
        logic        out_pending;
        logic        window_open;
        logic        drains;
        logic        all_acked;
        logic        local_empty;
        logic        keepalive_due;
        logic [15:0] rtt_sample;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  conn_state;
        logic        send_syn;
        logic        send_ack;
        logic        send_fin;
        logic        send_reset;
        logic        send_data;
        logic        accept_data;
        logic        report_loss;
        logic        drop_unacked;
        logic [17:0] timer_value;
    } out_item_t;

endpackage

>>> rtl/utp_connection_control_unit.sv
// Top level of the uTP connection control block.
// An event passes through the input register, then the result register; with out_ready
// held high one event is taken every cycle.
// Connection state is updated as an event moves from the input register to the
// result register, so the next event in the input register sees the updated state.
// Reset (rst_n low) returns phase to idle, clears the FIN and end-of-stream marks,
// sets srtt 100, deviation 0, timeout 1000 and both timeout registers to defaults.
module utp_connection_control_unit
    import utpcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [17:0]            cfg_data
);

    logic        s1_valid_reg, s1_valid_next;
    in_item_t    s1_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic [17:0] connect_timeout_reg, max_timeout_reg;

    phase_t      phase_reg, phase_next;
    logic        fin_done_reg, fin_done_next;
    logic [15:0] eof_seq_reg, eof_seq_next;
    logic        eof_known_reg, eof_known_next;
    logic [16:0] srtt_reg, srtt_next;
    logic [16:0] rtt_dev_reg, rtt_dev_next;
    logic [17:0] rto_reg, rto_next;

    logic        in_fire, out_free, s1_fire;

    // event decode helpers
    logic        push_able, empty_after, closing;
    logic [17:0] rto_dbl;
    logic        dbl_at_max;

    // RTT datapath
    logic signed [17:0] rtt_delta;
    logic        [16:0] rtt_abs;
    logic signed [17:0] dev_diff, dev_step, srtt_diff, srtt_step;
    logic signed [17:0] dev_sum, srtt_sum;
    logic        [16:0] dev_upd, srtt_upd;
    logic        [19:0] rto_sum;
    logic        [17:0] rto_rtt;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    assign push_able   = s1_reg.out_pending && s1_reg.window_open;
    assign empty_after = !s1_reg.out_pending || (s1_reg.window_open && s1_reg.drains);
    assign closing     = s1_reg.all_acked && s1_reg.local_empty;
    assign rto_dbl     = (rto_reg > RTO_HALF) ? RTO_MAX : {rto_reg[16:0], 1'b0};
    assign dbl_at_max  = rto_dbl >= max_timeout_reg;

    // RTT: dev += (|srtt - s| - dev) / 4, srtt += (s - srtt) / 8, truncating
    assign rtt_delta = $signed({1'b0, srtt_reg}) - $signed({2'b00, s1_reg.rtt_sample});
    assign rtt_abs   = rtt_delta[17] ? 17'(-rtt_delta) : rtt_delta[16:0];
    assign dev_diff  = $signed({1'b0, rtt_abs}) - $signed({1'b0, rtt_dev_reg});
    assign dev_step  = (dev_diff + $signed({16'b0, {2{dev_diff[17]}}})) >>> 2;
    assign dev_sum   = $signed({1'b0, rtt_dev_reg}) + dev_step;
    assign dev_upd   = dev_sum[16:0];
    assign srtt_diff = $signed({2'b00, s1_reg.rtt_sample}) - $signed({1'b0, srtt_reg});
    assign srtt_step = (srtt_diff + $signed({15'b0, {3{srtt_diff[17]}}})) >>> 3;
    assign srtt_sum  = $signed({1'b0, srtt_reg}) + srtt_step;
    assign srtt_upd  = srtt_sum[16:0];
    assign rto_sum   = {3'b000, srtt_upd} + {1'b0, dev_upd, 2'b00};
    assign rto_rtt   = (rto_sum < RTO_FLOOR) ? RTO_FLOOR[17:0] :
                       (rto_sum > {2'b00, RTO_MAX}) ? RTO_MAX : rto_sum[17:0];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (s1_reg.kind)
            KIND_PACKET:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                        phase_next = (s1_reg.pkt_type == PK_SYN) ? PH_CONNECTED : PH_CLOSED;
                    PH_SYN_SENT:
                        phase_next = (s1_reg.pkt_type == PK_STATE) ? PH_CONNECTED : PH_CLOSED;
                    PH_CONNECTED:
                    begin
                        if (s1_reg.pkt_type == PK_FIN)
                            phase_next = closing ? PH_CLOSED : PH_FINISHED;
                        else if (s1_reg.pkt_type != PK_DATA && s1_reg.pkt_type != PK_STATE)
                            phase_next = PH_CLOSED;
                    end
                    PH_FINISHED:
                    begin
                        if (s1_reg.pkt_type == PK_DATA || s1_reg.pkt_type == PK_STATE
                            || s1_reg.pkt_type == PK_FIN)
                            phase_next = closing ? PH_CLOSED : PH_FINISHED;
                        else
                            phase_next = PH_CLOSED;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            KIND_TIMEOUT:
            begin
                if (phase_reg == PH_SYN_SENT || phase_reg == PH_FINISHED)
                    phase_next = PH_CLOSED;
                else if (phase_reg == PH_CONNECTED && dbl_at_max)
                    phase_next = PH_FINISHED;
            end
            KIND_OPEN:
                if (phase_reg == PH_IDLE)
                    phase_next = PH_SYN_SENT;
            KIND_CLOSE:
                if (phase_reg == PH_CONNECTED)
                    phase_next = PH_FINISHED;
            KIND_RESET:
                phase_next = PH_CLOSED;
            default: phase_next = phase_reg;
        endcase
    end

    // action flags and the rest of the connection state
    always_comb
    begin
        out_next       = '0;
        eof_seq_next   = eof_seq_reg;
        eof_known_next = eof_known_reg;
        srtt_next      = srtt_reg;
        rtt_dev_next   = rtt_dev_reg;
        rto_next       = rto_reg;
        case (s1_reg.kind)
            KIND_PACKET:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (s1_reg.pkt_type == PK_SYN)
                        begin
                            out_next.send_ack = 1'b1;
                            rto_next = RTO_BASE;
                        end
                        else
                            out_next.send_reset = 1'b1;
                    end
                    PH_SYN_SENT:
                    begin
                        if (s1_reg.pkt_type == PK_STATE)
                            rto_next = RTO_BASE;
                        else
                            out_next.send_reset = 1'b1;
                    end
                    PH_CONNECTED:
                    begin
                        if (s1_reg.pkt_type == PK_DATA)
                        begin
                            out_next.accept_data = 1'b1;
                            out_next.send_data   = push_able;
                            out_next.send_ack    = !push_able;
                        end
                        else if (s1_reg.pkt_type == PK_STATE)
                            out_next.send_data = push_able;
                        else if (s1_reg.pkt_type == PK_FIN)
                        begin
                            eof_seq_next       = s1_reg.pkt_seq;
                            eof_known_next     = 1'b1;
                            out_next.send_data = push_able;
                            out_next.send_fin  = !fin_done_reg && empty_after;
                        end
                        else
                            out_next.send_reset = 1'b1;
                    end
                    PH_FINISHED:
                    begin
                        if (s1_reg.pkt_type == PK_DATA)
                        begin
                            out_next.accept_data = eof_known_reg
                                                   && (s1_reg.pkt_seq <= eof_seq_reg);
                            out_next.send_data   = push_able;
                            out_next.send_ack    = !push_able;
                            out_next.send_fin    = !fin_done_reg && empty_after;
                        end
                        else if (s1_reg.pkt_type == PK_STATE)
                        begin
                            out_next.send_data = push_able;
                            out_next.send_fin  = !fin_done_reg && empty_after;
                        end
                        else if (s1_reg.pkt_type == PK_FIN)
                        begin
                            eof_seq_next       = s1_reg.pkt_seq;
                            eof_known_next     = 1'b1;
                            out_next.send_data = push_able;
                            out_next.send_fin  = !fin_done_reg && empty_after;
                        end
                        else
                            out_next.send_reset = 1'b1;
                    end
                    default: out_next.send_reset = 1'b0;
                endcase
            end
            KIND_TIMEOUT:
            begin
                if (phase_reg == PH_CONNECTED)
                begin
                    out_next.report_loss = 1'b1;
                    rto_next             = rto_dbl;
                    out_next.send_data   = push_able;
                    out_next.send_fin    = dbl_at_max && !fin_done_reg && empty_after;
                    out_next.send_ack    = s1_reg.keepalive_due;
                end
            end
            KIND_RTT:
            begin
                srtt_next    = srtt_upd;
                rtt_dev_next = dev_upd;
                rto_next     = rto_rtt;
            end
            KIND_OPEN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    out_next.send_syn = 1'b1;
                    rto_next          = connect_timeout_reg;
                end
            end
            KIND_CLOSE:
            begin
                if (phase_reg == PH_CONNECTED)
                begin
                    out_next.send_data = push_able;
                    out_next.send_fin  = !fin_done_reg && empty_after;
                end
            end
            KIND_RESET:
            begin
                if (phase_reg != PH_CLOSED)
                begin
                    out_next.send_reset   = 1'b1;
                    out_next.drop_unacked = 1'b1;
                end
            end
            default: out_next.send_reset = 1'b0;
        endcase
        fin_done_next        = fin_done_reg || out_next.send_fin;
        out_next.conn_state  = phase_next;
        out_next.timer_value = rto_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            connect_timeout_reg <= CONNECT_TIMEOUT_RST;
            max_timeout_reg     <= MAX_TIMEOUT_RST;
            phase_reg           <= PH_IDLE;
            fin_done_reg        <= 1'b0;
            eof_seq_reg         <= '0;
            eof_known_reg       <= 1'b0;
            srtt_reg            <= SRTT_RST;
            rtt_dev_reg         <= '0;
            rto_reg             <= RTO_BASE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CONNECT_TIMEOUT: connect_timeout_reg <= cfg_data;
                    CFG_MAX_TIMEOUT:     max_timeout_reg     <= cfg_data;
                    default:             max_timeout_reg     <= max_timeout_reg;
                endcase
            end
            // advance connection state as the event leaves the input register
            if (s1_fire)
            begin
                phase_reg     <= phase_next;
                fin_done_reg  <= fin_done_next;
                eof_seq_reg   <= eof_seq_next;
                eof_known_reg <= eof_known_next;
                srtt_reg      <= srtt_next;
                rtt_dev_reg   <= rtt_dev_next;
                rto_reg       <= rto_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= in_data;
        if (s1_fire)
            out_reg <= out_next;
    end

endmodule

>>> rtl/utpcc_checker.sv
// Port-level checks for the uTP connection control block, bound to the top level.
module utpcc_checker
    import utpcc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_syn_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send_syn |->
            out_data.conn_state == PH_SYN_SENT && !out_data.send_reset)
        else $error("SYN without syn_sent state");

    a_drop_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.drop_unacked |->
            out_data.send_reset && out_data.conn_state == PH_CLOSED)
        else $error("drop without reset and close");

    a_loss_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.report_loss |->
            (out_data.conn_state == PH_CONNECTED || out_data.conn_state == PH_FINISHED)
            && out_data.timer_value != '0)
        else $error("loss reported outside a connection");

endmodule

bind utp_connection_control_unit utpcc_checker u_utpcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
